// ===== rtl/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg
// Shared widths, operation and status codes, and cell control types for the
// ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int OP_W    = 3;
  localparam int POS_W   = 6;
  localparam int ELEM_W  = 32;
  localparam int RDVAL_W = 32;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;

  localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT       = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_MATCH = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ         = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    M_HOLD,
    M_OPEN,
    M_CLOSE_AT,
    M_CLOSE_MATCH
  } cell_mode_t;

  typedef struct packed {
    logic       capture;
    cell_mode_t mode;
  } cell_ctl_t;

endpackage

// ===== rtl/ole_if.sv =====
// ----------------------------------------------------------------------------
// ole_if
// Request and result channels of the ordered list engine.
// ----------------------------------------------------------------------------
interface ole_in_if import ole_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  position;
  logic [ELEM_W-1:0] element_value;

  modport source (output valid, op, position, element_value, input ready);
  modport sink   (input valid, op, position, element_value, output ready);
endinterface

interface ole_out_if import ole_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RDVAL_W-1:0] read_value;
  logic [CNT_W-1:0]   count;
  logic [STAT_W-1:0]  status;

  modport source (output valid, read_value, count, status, input ready);
  modport sink   (input valid, read_value, count, status, output ready);
endinterface

// ===== rtl/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of up to CAPACITY entries held in a row of cells.
// Request taken in S_IDLE, which latches per-cell match flags; S_EXEC then runs
// the first-match prefix chain, shifts cells and registers the result word, waiting
// while the previous result is unaccepted. One request at a time (ready only in S_IDLE).
// Reset: count and handshake state cleared; entry contents undefined.
// ----------------------------------------------------------------------------
module ordered_list_engine import ole_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  ole_in_if.sink   in_ch,
  ole_out_if.source out_ch
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int RW   = (VALUE_WIDTH > ELEM_W) ? VALUE_WIDTH : ELEM_W;
  localparam int OCW  = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                  state_r;
  logic [OP_W-1:0]         req_op_r;
  logic [POS_W-1:0]        req_pos_r;
  logic [VALUE_WIDTH-1:0]  req_val_r;
  logic [CW-1:0]           count_r;
  logic                    out_valid_r;
  logic [RDVAL_W-1:0]      out_read_value_r;
  logic [CNT_W-1:0]        out_count_r;
  logic [STAT_W-1:0]       out_status_r;

  logic [VALUE_WIDTH-1:0]  cell_data [CAPACITY];
  logic [CAPACITY:0]       seen;
  cell_ctl_t               ctl;
  cell_mode_t              mode_sel;
  logic [IW-1:0]           pivot;
  logic [VALUE_WIDTH-1:0]  cell_val;

  logic                    in_fire;
  logic                    exec_go;
  logic [RW-1:0]           in_val_wide;
  logic [VALUE_WIDTH-1:0]  in_val;
  logic [CMPW-1:0]         pos_c;
  logic [CMPW-1:0]         cnt_c;
  logic [IW-1:0]           rd_idx;
  logic [RW-1:0]           rd_wide;
  logic                    full;
  logic [CW-1:0]           count_nxt;
  logic [OCW-1:0]          count_out_wide;
  logic [STAT_W-1:0]       status_nxt;
  logic [RDVAL_W-1:0]      read_value_nxt;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_read_value_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.status     = out_status_r;

  assign in_fire = in_ch.valid && (state_r == S_IDLE);
  assign exec_go = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  assign in_val_wide = RW'(in_ch.element_value);
  assign in_val      = in_val_wide[VALUE_WIDTH-1:0];
  assign cell_val    = (state_r == S_IDLE) ? in_val : req_val_r;

  assign pos_c   = CMPW'(req_pos_r);
  assign cnt_c   = CMPW'(count_r);
  assign rd_idx  = pos_c[IW-1:0];
  assign rd_wide = RW'(cell_data[rd_idx]);
  assign full    = (count_r == CW'(CAPACITY));

  assign ctl.capture = in_fire;
  assign ctl.mode    = exec_go ? mode_sel : M_HOLD;

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left;
    logic [VALUE_WIDTH-1:0] right;
    if (g == 0) begin : g_first
      assign left = cell_val;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    ole_cell #(
      .IDX (g),
      .VW  (VALUE_WIDTH),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .val      (cell_val),
      .left     (left),
      .right    (right),
      .pivot    (pivot),
      .count    (count_r),
      .seen_in  (seen[g]),
      .seen_out (seen[g+1]),
      .data     (cell_data[g])
    );
  end

  always_comb begin
    mode_sel       = M_HOLD;
    pivot          = '0;
    count_nxt      = count_r;
    status_nxt     = ST_OK;
    read_value_nxt = '0;
    case (req_op_r)
      OP_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          mode_sel  = M_OPEN;
          pivot     = cnt_c[IW-1:0];
          count_nxt = count_r + CW'(1);
        end
      end
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (pos_c > cnt_c) begin
          status_nxt = ST_RANGE;
        end else begin
          mode_sel  = M_OPEN;
          pivot     = pos_c[IW-1:0];
          count_nxt = count_r + CW'(1);
        end
      end
      OP_REMOVE_MATCH: begin
        if (seen[CAPACITY]) begin
          mode_sel  = M_CLOSE_MATCH;
          count_nxt = count_r - CW'(1);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      OP_REMOVE_AT: begin
        if (pos_c >= cnt_c) begin
          status_nxt = ST_RANGE;
        end else begin
          mode_sel  = M_CLOSE_AT;
          pivot     = pos_c[IW-1:0];
          count_nxt = count_r - CW'(1);
        end
      end
      OP_READ: begin
        if (pos_c >= cnt_c) begin
          status_nxt = ST_RANGE;
        end else begin
          read_value_nxt = rd_wide[RDVAL_W-1:0];
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  assign count_out_wide = OCW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            req_op_r  <= in_ch.op;
            req_pos_r <= in_ch.position;
            req_val_r <= in_val;
            state_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            count_r          <= count_nxt;
            out_read_value_r <= read_value_nxt;
            out_count_r      <= count_out_wide[CNT_W-1:0];
            out_status_r     <= status_nxt;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ole_cell.sv =====
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds an entry, flags a match against the request word and
// shifts toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module ole_cell import ole_pkg::*; #(
  parameter int IDX = 0,
  parameter int VW  = 32,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [VW-1:0] val,
  input  logic [VW-1:0] left,
  input  logic [VW-1:0] right,
  input  logic [IW-1:0] pivot,
  input  logic [CW-1:0] count,
  input  logic          seen_in,
  output logic          seen_out,
  output logic [VW-1:0] data
);

  localparam logic [IW-1:0] MY_PIV = IW'(IDX);
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [VW-1:0] data_r;
  logic [VW-1:0] data_nxt;
  logic          match_r;

  assign seen_out = seen_in | match_r;
  assign data     = data_r;

  always_comb begin
    data_nxt = data_r;
    case (ctl.mode)
      M_OPEN: begin
        if (MY_PIV > pivot) begin
          data_nxt = left;
        end else if (MY_PIV == pivot) begin
          data_nxt = val;
        end
      end
      M_CLOSE_AT: begin
        if (MY_PIV >= pivot) begin
          data_nxt = right;
        end
      end
      M_CLOSE_MATCH: begin
        if (seen_out) begin
          data_nxt = right;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.capture) begin
      match_r <= (data_r == val) && (MY_IDX < count);
    end
  end

endmodule

// ===== tb/ordered_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_tb
// Self-checking bench for the ordered list engine. A directed opening covers
// the empty list, inserts at the head, at the end and past it, first-match
// removal, range errors and the spare opcodes. Random traffic follows in
// fill, drain and blended phases that run the list to full and back to
// empty. Both channels stall in random bursts, and every result word is
// checked against a queue-based model of the list.
// ----------------------------------------------------------------------------

class ordered_list_checker;
  localparam int LIST_CAPACITY = 64;

  typedef logic [ole_pkg::CNT_W-1:0] list_count_t;

  typedef struct packed {
    logic [ole_pkg::RDVAL_W-1:0] read_value;
    logic [ole_pkg::CNT_W-1:0]   count;
    logic [ole_pkg::STAT_W-1:0]  status;
  } list_result_t;

  logic [ole_pkg::ELEM_W-1:0] list_entries[$];
  list_result_t               expected_results[$];
  int                         errors;

  function void take_request(logic [ole_pkg::OP_W-1:0] op,
                             logic [ole_pkg::POS_W-1:0] pos,
                             logic [ole_pkg::ELEM_W-1:0] value);
    list_result_t res;
    int           hit;
    res        = '0;
    res.status = ole_pkg::ST_OK;
    hit        = -1;
    case (op)
      ole_pkg::OP_APPEND: begin
        if (list_entries.size() >= LIST_CAPACITY) res.status = ole_pkg::ST_FULL;
        else list_entries.push_back(value);
      end
      ole_pkg::OP_INSERT: begin
        if (list_entries.size() >= LIST_CAPACITY) res.status = ole_pkg::ST_FULL;
        else if (pos > list_entries.size()) res.status = ole_pkg::ST_RANGE;
        else list_entries.insert(pos, value);
      end
      ole_pkg::OP_REMOVE_MATCH: begin
        for (int i = 0; i < list_entries.size() && hit < 0; i++)
          if (list_entries[i] == value) hit = i;
        if (hit < 0) res.status = ole_pkg::ST_NOTFOUND;
        else list_entries.delete(hit);
      end
      ole_pkg::OP_REMOVE_AT: begin
        if (pos >= list_entries.size()) res.status = ole_pkg::ST_RANGE;
        else list_entries.delete(pos);
      end
      ole_pkg::OP_READ: begin
        if (pos >= list_entries.size()) res.status = ole_pkg::ST_RANGE;
        else res.read_value = list_entries[pos];
      end
      default: ;
    endcase
    res.count = list_count_t'(list_entries.size());
    expected_results.push_back(res);
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [ole_pkg::RDVAL_W-1:0] read_value,
                             logic [ole_pkg::CNT_W-1:0] count,
                             logic [ole_pkg::STAT_W-1:0] status);
    list_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result word, read_value %0h count %0d status %0d",
               $time, read_value, count, status);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("read_value", want.read_value, read_value);
    compare_field("count", 32'(want.count), 32'(count));
    compare_field("status", 32'(want.status), 32'(status));
  endfunction
endclass

module ordered_list_engine_tb import ole_pkg::*; ();

  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_WORDS = 700;
  localparam int TAIL_WORDS   = 100;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} traffic_mix_t;

  logic clk;
  logic rst_n;
  bit   quiet_tail;
  bit   steady_phase;

  ole_in_if  in_ch();
  ole_out_if out_ch();

  ordered_list_engine u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ordered_list_checker list_sb = new();

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("ordered_list_engine_tb NOT OK");
    $finish;
  end

  initial begin : result_stall
    int  n;
    bit  lvl;
    out_ch.ready = 1'b0;
    forever begin
      lvl = quiet_tail || ($urandom_range(0, 2) != 0);
      n   = lvl ? $urandom_range(1, 20) : $urandom_range(1, 11);
      repeat (n) begin
        @(negedge clk);
        out_ch.ready <= lvl;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      list_sb.check_result(out_ch.read_value, out_ch.count, out_ch.status);
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [ELEM_W-1:0] value);
    if (!quiet_tail && !steady_phase && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.position      <= pos;
    in_ch.element_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    list_sb.take_request(op, pos, value);
  endtask

  task automatic random_word(input traffic_mix_t mix);
    int                r;
    int                cnt;
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] value;
    cnt = list_sb.list_entries.size();
    r   = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 45) op = OP_APPEND;
        else if (r < 85) op = OP_INSERT;
        else if (r < 90) op = OP_REMOVE_MATCH;
        else if (r < 93) op = OP_REMOVE_AT;
        else if (r < 98) op = OP_READ;
        else op = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      end
      MIX_DRAIN: begin
        if (r < 10) op = OP_APPEND;
        else if (r < 20) op = OP_INSERT;
        else if (r < 55) op = OP_REMOVE_MATCH;
        else if (r < 80) op = OP_REMOVE_AT;
        else if (r < 97) op = OP_READ;
        else op = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      end
      default: begin
        if (r < 20) op = OP_APPEND;
        else if (r < 40) op = OP_INSERT;
        else if (r < 60) op = OP_REMOVE_MATCH;
        else if (r < 75) op = OP_REMOVE_AT;
        else if (r < 95) op = OP_READ;
        else op = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      end
    endcase

    // mostly aim at or just past the occupied range
    if ($urandom_range(0, 9) < 7)
      pos = POS_W'((cnt > 63) ? $urandom_range(0, 63) : $urandom_range(0, cnt));
    else pos = POS_W'($urandom_range(0, 63));

    // small pool values give duplicates, so first-match removal matters
    r = $urandom_range(0, 9);
    if (op == OP_REMOVE_MATCH && cnt > 0 && r < 6)
      value = list_sb.list_entries[$urandom_range(0, cnt - 1)];
    else if (r < 4) value = $urandom_range(0, 7);
    else if (r == 4) value = '1;
    else if (r == 5) value = '0;
    else value = $urandom();
    send_word(op, pos, value);
  endtask

  initial begin : stimulus
    int           done;
    int           phase_len;
    traffic_mix_t mix;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_APPEND;
    in_ch.position      = '0;
    in_ch.element_value = '0;
    quiet_tail          = 1'b0;
    steady_phase        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list: range and not-found errors, then insert past the end
    send_word(OP_READ, 6'd0, '0);
    send_word(OP_REMOVE_AT, 6'd0, '0);
    send_word(OP_REMOVE_MATCH, 6'd0, 32'h5);
    send_word(OP_INSERT, 6'd1, 32'h1);
    send_word(OP_INSERT, 6'd0, '1);
    send_word(OP_APPEND, 6'd63, '0);
    send_word(OP_INSERT, 6'd2, 32'h1234_5678);
    send_word(OP_INSERT, 6'd1, 32'h5);
    send_word(OP_APPEND, 6'd0, 32'h5);
    for (int i = 0; i < 6; i++) send_word(OP_READ, POS_W'(i), '0);
    send_word(OP_READ, 6'd63, '0);
    send_word(OP_REMOVE_MATCH, 6'd0, 32'h5);
    send_word(OP_REMOVE_MATCH, 6'd0, 32'hDEAD_BEEF);
    send_word(OP_REMOVE_AT, 6'd0, '0);
    send_word(OP_REMOVE_AT, 6'd63, '0);
    send_word(OP_INSERT, 6'd63, '0);
    send_word(OP_SPARE_5, 6'd63, '1);
    send_word(OP_SPARE_6, 6'd63, '1);
    send_word(OP_SPARE_7, 6'd63, '1);

    // first phase runs the list up to full and keeps pushing against it
    done      = 0;
    mix       = MIX_FILL;
    phase_len = 150;
    while (done < RANDOM_WORDS) begin
      quiet_tail = (done >= RANDOM_WORDS - TAIL_WORDS);
      random_word(mix);
      done++;
      phase_len--;
      if (phase_len == 0) begin
        mix          = traffic_mix_t'($urandom_range(0, 2));
        phase_len    = $urandom_range(60, 120);
        steady_phase = ($urandom_range(0, 3) == 0);
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (list_sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (list_sb.errors == 0) begin
      $display("ordered_list_engine_tb OK");
    end else begin
      $display("ordered_list_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
